// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // decisions of one step, handed from the step logic to the datapath
  typedef struct packed {
    status_t status;
    logic    wr_en;
    logic    rd_en;
    logic    rd_front;
    logic    empty_nxt;
    logic    set_head;
    logic    set_tail;
    logic    pop_ok;
    logic    pop_front;
  } step_ctl_t;

endpackage

// ===== rtl/cdq_ram.sv =====
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cdq_step.sv =====
module cdq_step #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  cdq_pkg::req_t                  req,
  input  logic [$clog2(DEPTH)-1:0]       head_ptr,
  input  logic [$clog2(DEPTH)-1:0]       tail_ptr,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic                           empty,
  output cdq_pkg::step_ctl_t             ctl,
  output logic [$clog2(DEPTH)-1:0]       head_nxt,
  output logic [$clog2(DEPTH)-1:0]       tail_nxt,
  output logic [$clog2(DEPTH+1)-1:0]     count_nxt,
  output logic [$clog2(DEPTH)-1:0]       wr_addr,
  output logic [$clog2(DEPTH)-1:0]       rd_addr
);
  import cdq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             full, last_one;

  // pointers wrap both ways, also for depths that are not powers of two
  assign head_inc = (head_ptr == PTR_LAST) ? '0 : head_ptr + PTR_W'(1);
  assign head_dec = (head_ptr == '0) ? PTR_LAST : head_ptr - PTR_W'(1);
  assign tail_inc = (tail_ptr == PTR_LAST) ? '0 : tail_ptr + PTR_W'(1);
  assign tail_dec = (tail_ptr == '0) ? PTR_LAST : tail_ptr - PTR_W'(1);

  assign full     = (count == CNT_FULL);
  assign last_one = (count == CNT_W'(1));

  always_comb begin
    ctl       = '0;
    ctl.status    = STAT_DONE;
    ctl.empty_nxt = empty;
    head_nxt  = head_ptr;
    tail_nxt  = tail_ptr;
    count_nxt = count;
    wr_addr   = '0;
    rd_addr   = '0;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          ctl.status = STAT_FULL;
        end else if (empty) begin
          head_nxt      = '0;
          tail_nxt      = '0;
          count_nxt     = CNT_W'(1);
          ctl.empty_nxt = 1'b0;
          ctl.wr_en     = 1'b1;
          ctl.set_head  = 1'b1;
          ctl.set_tail  = 1'b1;
        end else if (req == REQ_PUSH_FRONT) begin
          head_nxt     = head_dec;
          wr_addr      = head_dec;
          count_nxt    = count + CNT_W'(1);
          ctl.wr_en    = 1'b1;
          ctl.set_head = 1'b1;
        end else begin
          tail_nxt     = tail_inc;
          wr_addr      = tail_inc;
          count_nxt    = count + CNT_W'(1);
          ctl.wr_en    = 1'b1;
          ctl.set_tail = 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty) begin
          ctl.status = STAT_EMPTY;
        end else begin
          ctl.pop_ok    = 1'b1;
          ctl.pop_front = (req == REQ_POP_FRONT);
          count_nxt     = count - CNT_W'(1);
          if (last_one) begin
            head_nxt      = '0;
            tail_nxt      = '0;
            ctl.empty_nxt = 1'b1;
          end else if (req == REQ_POP_FRONT) begin
            head_nxt     = head_inc;
            rd_addr      = head_inc;
            ctl.rd_en    = 1'b1;
            ctl.rd_front = 1'b1;
          end else begin
            tail_nxt  = tail_dec;
            rd_addr   = tail_dec;
            ctl.rd_en = 1'b1;
          end
        end
      end
      default: begin
        ctl.status = STAT_DONE;
      end
    endcase
  end

endmodule

// ===== rtl/circular_deque_core.sv =====
// channel  | handshake              | ports
// ---------+------------------------+-----------------------------------------------
// request  | start high, busy low   | in_req_type, in_push_value
// result   | out_valid, one cycle   | out_status, out_popped_value, out_entry_count,
//          |                        | out_head_value, out_tail_value, out_ends_valid
//
// a push or a rejected request returns its word on the cycle after it is taken;
// busy stays low, so a request can be taken every cycle
// a pop that leaves entries raises busy for one cycle while the new end word is
// read back from the slot memory; its result word is registered as the fill state ends
// rst_n is synchronous; the slot memory is never cleared, only read where a push wrote
// results cannot be held off: each word shows for exactly one cycle
module circular_deque_core #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [cdq_pkg::REQ_W-1:0]       in_req_type,
  input  logic signed [cdq_pkg::DATA_W-1:0]      in_push_value,
  output logic                                   out_valid,
  output logic        [cdq_pkg::STAT_W-1:0]      out_status,
  output logic signed [cdq_pkg::DATA_W-1:0]      out_popped_value,
  output logic        [cdq_pkg::CNT_OUT_W-1:0]   out_entry_count,
  output logic signed [cdq_pkg::DATA_W-1:0]      out_head_value,
  output logic signed [cdq_pkg::DATA_W-1:0]      out_tail_value,
  output logic                                   out_ends_valid
);
  import cdq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer: idle takes requests, fill waits on the memory read
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FILL = 2'b10
  } fsm_t;

  fsm_t state_r, state_nxt;

  // pointer and count state
  logic [PTR_W-1:0] head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0] tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             empty_r, empty_nxt;

  // end words kept beside the memory so popped words and result fields need no read
  logic [DATA_W-1:0] head_val_r, head_val_nxt;
  logic [DATA_W-1:0] tail_val_r, tail_val_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              fill_front_r, fill_front_nxt;

  logic               accept;
  step_ctl_t          ctl;
  logic [PTR_W-1:0]   step_head, step_tail, wr_addr, rd_addr;
  logic [CNT_W-1:0]   step_count;
  logic [DATA_W-1:0]  rd_data;
  logic [CNT_W+3:0]   cnt_ext;

  assign accept = start && (state_r == S_IDLE);

  cdq_step #(.DEPTH(DEPTH)) u_step (
    .req       (req_t'(in_req_type)),
    .head_ptr  (head_ptr_r),
    .tail_ptr  (tail_ptr_r),
    .count     (count_r),
    .empty     (empty_r),
    .ctl       (ctl),
    .head_nxt  (step_head),
    .tail_nxt  (step_tail),
    .count_nxt (step_count),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // slot memory: pushes write, pops read the next end; never both in one request
  cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_slots (
    .clk     (clk),
    .wr_en   (accept && ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (accept && ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    head_ptr_nxt   = head_ptr_r;
    tail_ptr_nxt   = tail_ptr_r;
    count_nxt      = count_r;
    empty_nxt      = empty_r;
    head_val_nxt   = head_val_r;
    tail_val_nxt   = tail_val_r;
    popped_nxt     = popped_r;
    status_nxt     = status_r;
    fill_front_nxt = fill_front_r;
    out_valid_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          head_ptr_nxt   = step_head;
          tail_ptr_nxt   = step_tail;
          count_nxt      = step_count;
          empty_nxt      = ctl.empty_nxt;
          status_nxt     = ctl.status;
          fill_front_nxt = ctl.rd_front;
          // popped word comes from the cached end registers
          if (ctl.pop_ok) begin
            popped_nxt = ctl.pop_front ? head_val_r : tail_val_r;
          end else begin
            popped_nxt = '0;
          end
          if (ctl.set_head) begin
            head_val_nxt = in_push_value;
          end
          if (ctl.set_tail) begin
            tail_val_nxt = in_push_value;
          end
          if (ctl.rd_en) begin
            state_nxt = S_FILL;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_FILL: begin
        // refill the end that moved inward, then release the result
        if (fill_front_r) begin
          head_val_nxt = rd_data;
        end else begin
          tail_val_nxt = rd_data;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_ptr_r  <= '0;
      tail_ptr_r  <= '0;
      count_r     <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_ptr_r  <= head_ptr_nxt;
      tail_ptr_r  <= tail_ptr_nxt;
      count_r     <= count_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    head_val_r   <= head_val_nxt;
    tail_val_r   <= tail_val_nxt;
    popped_r     <= popped_nxt;
    status_r     <= status_nxt;
    fill_front_r <= fill_front_nxt;
  end

  // count shown modulo 16
  assign cnt_ext = {4'b0, count_r};

  assign busy             = (state_r == S_FILL);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_entry_count  = cnt_ext[CNT_OUT_W-1:0];
  assign out_head_value   = empty_r ? '0 : head_val_r;
  assign out_tail_value   = empty_r ? '0 : tail_val_r;
  assign out_ends_valid   = !empty_r;

endmodule

// ===== rtl/cdq_checker.sv =====
module cdq_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic        [cdq_pkg::REQ_W-1:0]       in_req_type,
  input logic signed [cdq_pkg::DATA_W-1:0]      in_push_value,
  input logic                                   out_valid,
  input logic        [cdq_pkg::STAT_W-1:0]      out_status,
  input logic signed [cdq_pkg::DATA_W-1:0]      out_popped_value,
  input logic        [cdq_pkg::CNT_OUT_W-1:0]   out_entry_count,
  input logic signed [cdq_pkg::DATA_W-1:0]      out_head_value,
  input logic signed [cdq_pkg::DATA_W-1:0]      out_tail_value,
  input logic                                   out_ends_valid
);
  import cdq_pkg::*;

  // every result word traces back to a request or to the end of a refill
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a request");

  // a refill lasts exactly one cycle
  a_fill_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // no result during a refill
  a_no_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result word while busy");

  // an empty deque shows zero ends and a zero entry count
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ends_valid) |->
      (out_head_value == '0 && out_tail_value == '0 && out_entry_count == '0))
    else $error("empty deque with nonzero end fields");

  // a rejected pop returns zero and leaves the deque empty
  a_rejected_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |->
      (out_popped_value == '0 && !out_ends_valid))
    else $error("rejected pop with data or entries");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
